// ===== rtl/core/lvsm_pkg.sv =====
`timescale 1ns / 1ps
package lvsm_pkg;
   localparam logic [1:0] FUNC_STORE = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 17;
   localparam int COUNT_W  = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic [1:0]          func;
      logic [15:0]         frame_addr;
      logic [SAMPLE_W-1:0] left_in;
      logic [SAMPLE_W-1:0] right_in;
      logic [LEN_W-1:0]    voice_length;
      logic                loop_enable;
   } cmd_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mix_left;
      logic [SAMPLE_W-1:0] mix_right;
      logic [COUNT_W-1:0]  active_voices;
      logic                status;
   } rsp_type;
endpackage

// ===== rtl/core/lvsm_queue.sv =====
`timescale 1ns / 1ps
module lvsm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  lvsm_pkg::cmd_type  wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output lvsm_pkg::cmd_type  rd_data
);
   // Two-entry queue between front and back.
   lvsm_pkg::cmd_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_go, rd_go;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr_go    = wr_valid && wr_ready;
   assign rd_go    = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wr_go ? ~wp_ff : wp_ff;
      rp_in  = rd_go ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, wr_go} - {1'b0, rd_go};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr_go) mem_ff[wp_ff] <= wr_data;
   end
endmodule

// ===== rtl/core/lvsm_engine.sv =====
`timescale 1ns / 1ps
module lvsm_engine #(
   parameter int VOICES     = 8,
   parameter int MEM_FRAMES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  lvsm_pkg::cmd_type  cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output lvsm_pkg::rsp_type  out_data
);
   localparam int AW = (MEM_FRAMES > 1) ? $clog2(MEM_FRAMES) : 1;
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SW = 16 + $clog2(VOICES + 1) + 1;
   localparam int CW = $clog2(VOICES + 1) + 1;
   localparam logic [VW:0] VLAST = (VW+1)'(VOICES - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [31:0] mem [MEM_FRAMES];
   logic [31:0] rdata_ff;

   logic [VOICES-1:0] valid_ff, valid_in;
   logic [15:0]       start_ff [VOICES];
   logic [16:0]       frames_ff [VOICES];
   logic [16:0]       pos_ff [VOICES];
   logic              loops_ff [VOICES];

   logic [2:0]        state_ff, state_in;
   logic [VW:0]       v_ff, v_in;
   logic signed [SW-1:0] suml_ff, suml_in, sumr_ff, sumr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   lvsm_pkg::rsp_type res_ff, res_in;
   logic              ovalid_ff, ovalid_in;

   logic              free_found;
   logic [VW-1:0]     free_idx;
   logic [VW-1:0]     vi;
   logic [16:0]       addr_sum;
   logic [AW-1:0]     raddr;
   logic [17:0]       pos_next;
   logic              do_start, do_store, pos_wr, rd_en;

   assign vi        = v_ff[VW-1:0];
   assign cmd_ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign out_valid = ovalid_ff;
   assign out_data  = res_ff;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VW'(i);
         end
      end
   end

   assign addr_sum = {1'b0, start_ff[vi]} + pos_ff[vi];
   assign raddr    = AW'(addr_sum);
   assign pos_next = {1'b0, pos_ff[vi]} + 18'd1;

   function automatic logic [15:0] sat16(input logic signed [SW-1:0] s);
      if (s < -SW'(32768)) return 16'h8000;
      if (s > SW'(32767))  return 16'h7fff;
      return s[15:0];
   endfunction

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      suml_in   = suml_ff;
      sumr_in   = sumr_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      ovalid_in = ovalid_ff && !out_ready;
      valid_in  = valid_ff;
      do_start  = 1'b0;
      do_store  = 1'b0;
      pos_wr    = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               res_in = '0;
               unique case (cmd.func)
                  lvsm_pkg::FUNC_STORE: begin
                     do_store  = 1'b1;
                     ovalid_in = 1'b1;
                  end
                  lvsm_pkg::FUNC_START: begin
                     if (cmd.voice_length != '0) begin
                        if (free_found) begin
                           do_start = 1'b1;
                           valid_in[free_idx] = 1'b1;
                        end else begin
                           res_in.status = 1'b1;
                        end
                     end
                     ovalid_in = 1'b1;
                  end
                  lvsm_pkg::FUNC_TICK: begin
                     v_in     = '0;
                     suml_in  = '0;
                     sumr_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: ovalid_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (v_ff > VLAST) begin
               state_in = ST_OUT;
            end else if (valid_ff[vi]) begin
               rd_en    = 1'b1;
               state_in = ST_ACC;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         ST_ACC: begin
            suml_in = suml_ff + SW'($signed(rdata_ff[15:0]));
            sumr_in = sumr_ff + SW'($signed(rdata_ff[31:16]));
            cnt_in  = cnt_ff + 1'b1;
            pos_wr  = 1'b1;
            if (pos_next >= {1'b0, frames_ff[vi]} && !loops_ff[vi]) valid_in[vi] = 1'b0;
            v_in     = v_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_OUT: begin
            res_in.mix_left  = sat16(suml_ff);
            res_in.mix_right = sat16(sumr_ff);
            res_in.active_voices = (cnt_ff > CW'(15)) ? lvsm_pkg::COUNT_MAX
                                                      : cnt_ff[3:0];
            res_in.status = 1'b0;
            ovalid_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         ovalid_ff <= ovalid_in;
      end
      v_ff    <= v_in;
      suml_ff <= suml_in;
      sumr_ff <= sumr_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      if (do_start) begin
         start_ff[free_idx]  <= cmd.frame_addr;
         frames_ff[free_idx] <= cmd.voice_length;
         pos_ff[free_idx]    <= '0;
         loops_ff[free_idx]  <= cmd.loop_enable;
      end
      if (pos_wr) begin
         pos_ff[vi] <= (pos_next >= {1'b0, frames_ff[vi]}) ? 17'd0 : pos_next[16:0];
      end
   end

   // Sample memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_store) mem[AW'(cmd.frame_addr)] <= {cmd.right_in, cmd.left_in};
      if (rd_en) rdata_ff <= mem[raddr];
   end
endmodule

// ===== rtl/core/looping_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Word
// req_*     in         func, frame_addr, left_in, right_in, voice_length, loop_enable
// rsp_*     out        mix_left, mix_right, active_voices, status
//
// Store and start answer with a registered result word.
// Tick walks the voice table one idle voice a cycle; an active voice passes through
// ST_SCAN and then ST_ACC because of the registered memory read.
// Reset clears the voice table valid bits and the queue; memory is not cleared.
// A two-word queue lets the input side accept while the mixer is busy or
// its result waits.
module looping_voice_sample_mixer #(
   parameter int VOICES     = 8,
   parameter int MEM_FRAMES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_frame_addr,
   input  logic signed [15:0] req_left_in,
   input  logic signed [15:0] req_right_in,
   input  logic [16:0] req_voice_length,
   input  logic        req_loop_enable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_mix_left,
   output logic signed [15:0] rsp_mix_right,
   output logic [3:0]  rsp_active_voices,
   output logic        rsp_status
);
   lvsm_pkg::cmd_type in_cmd, q_cmd;
   lvsm_pkg::rsp_type res;
   logic q_valid, q_ready;

   always_comb begin
      in_cmd.func         = req_func;
      in_cmd.frame_addr   = req_frame_addr;
      in_cmd.left_in      = req_left_in;
      in_cmd.right_in     = req_right_in;
      in_cmd.voice_length = req_voice_length;
      in_cmd.loop_enable  = req_loop_enable;
   end

   lvsm_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(req_valid), .wr_ready(req_ready), .wr_data(in_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   lvsm_engine #(.VOICES(VOICES), .MEM_FRAMES(MEM_FRAMES)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(res)
   );

   assign rsp_mix_left      = res.mix_left;
   assign rsp_mix_right     = res.mix_right;
   assign rsp_active_voices = res.active_voices;
   assign rsp_status        = res.status;
endmodule

// ===== verif/tb_looping_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
module tb_looping_voice_sample_mixer;
   localparam int NVOICE = 8;
   localparam int RANDOM_WORDS = 880;
   localparam int IDLE_LIMIT = 5000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      lvsm_pkg::cmd_type cmd;
      bit      known;
      lvsm_pkg::rsp_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = lvsm_pkg::FUNC_STORE;
   logic [15:0] req_frame_addr = '0;
   logic signed [15:0] req_left_in = '0;
   logic signed [15:0] req_right_in = '0;
   logic [16:0] req_voice_length = '0;
   logic req_loop_enable = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_mix_left;
   logic signed [15:0] rsp_mix_right;
   logic [3:0] rsp_active_voices;
   logic rsp_status;

   // Shadow of the mixer state.
   logic [31:0] frame_mem [0:65535];
   bit          frame_written [0:65535];
   bit          vc_busy [NVOICE];
   logic [15:0] vc_start [NVOICE];
   int          vc_frames [NVOICE];
   int          vc_pos [NVOICE];
   bit          vc_loops [NVOICE];

   lvsm_pkg::rsp_type pending_mix [$];
   row_type directed_rows [$];
   int errors = 0;
   int words_out = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   looping_voice_sample_mixer u_top (.*);

   function automatic lvsm_pkg::rsp_type mix_step(lvsm_pkg::cmd_type c);
      lvsm_pkg::rsp_type r;
      int sum_l, sum_r, count, slot;
      logic [15:0] a;
      logic [31:0] w;
      sum_l = 0;
      sum_r = 0;
      count = 0;
      r = '0;
      case (c.func)
         lvsm_pkg::FUNC_STORE: begin
            frame_mem[c.frame_addr] = {c.right_in, c.left_in};
            frame_written[c.frame_addr] = 1;
         end
         lvsm_pkg::FUNC_START: begin
            if (c.voice_length != 0) begin
               slot = -1;
               for (int v = 0; v < NVOICE; v++)
                  if (!vc_busy[v] && slot < 0) slot = v;
               if (slot < 0) begin
                  r.status = 1'b1;
               end else begin
                  vc_busy[slot] = 1;
                  vc_start[slot] = c.frame_addr;
                  vc_frames[slot] = c.voice_length;
                  vc_pos[slot] = 0;
                  vc_loops[slot] = c.loop_enable;
               end
            end
         end
         lvsm_pkg::FUNC_TICK: begin
            for (int v = 0; v < NVOICE; v++) begin
               if (vc_busy[v]) begin
                  a = vc_start[v] + 16'(vc_pos[v]);
                  w = frame_mem[a];
                  sum_l += int'($signed(w[15:0]));
                  sum_r += int'($signed(w[31:16]));
                  count++;
                  vc_pos[v]++;
                  if (vc_pos[v] >= vc_frames[v]) begin
                     if (vc_loops[v]) vc_pos[v] = 0;
                     else vc_busy[v] = 0;
                  end
               end
            end
            if (sum_l > 32767) sum_l = 32767;
            if (sum_l < -32768) sum_l = -32768;
            if (sum_r > 32767) sum_r = 32767;
            if (sum_r < -32768) sum_r = -32768;
            if (count > 15) count = 15;
            r.mix_left = sum_l[15:0];
            r.mix_right = sum_r[15:0];
            r.active_voices = count[3:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(logic [1:0] f, logic [15:0] a, logic [15:0] l,
                                   logic [15:0] rt, logic [16:0] len, logic lp,
                                   bit known, logic st);
      row_type row;
      row.cmd = '{f, a, l, rt, len, lp};
      row.known = known;
      row.res = '0;
      row.res.status = st;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic logic [15:0] pick_addr();
      if ($urandom_range(0, 4) != 0) return 16'hFFE0 + 16'($urandom_range(0, 63));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Draws one random word; a tick whose voices would read unwritten frames
   // turns into a store of the first such frame.
   function automatic lvsm_pkg::cmd_type draw_word();
      lvsm_pkg::cmd_type c;
      int kind, loopers;
      logic [15:0] a;
      kind = $urandom_range(0, 99);
      c = '{lvsm_pkg::FUNC_STORE, pick_addr(), pick_sample(), pick_sample(), 17'd0, 1'b0};
      if (kind < 30) return c;
      if (kind < 50) begin
         loopers = 0;
         for (int v = 0; v < NVOICE; v++) if (vc_busy[v] && vc_loops[v]) loopers++;
         c.func = lvsm_pkg::FUNC_START;
         c.voice_length = 17'($urandom_range(1, 24));
         if ($urandom_range(0, 19) == 0) c.voice_length = 17'd0;
         if ($urandom_range(0, 99) == 0) c.voice_length = 17'($urandom_range(1000, 65536));
         c.loop_enable = (loopers < 3 && c.voice_length <= 24) ? 1'($urandom) : 1'b0;
         return c;
      end
      if (kind < 95) begin
         for (int v = 0; v < NVOICE; v++) begin
            a = vc_start[v] + 16'(vc_pos[v]);
            if (vc_busy[v] && !frame_written[a]) begin
               c.frame_addr = a;
               return c;
            end
         end
         c.func = lvsm_pkg::FUNC_TICK;
         return c;
      end
      c = '{FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
            17'($urandom_range(0, 65536)), 1'($urandom)};
      return c;
   endfunction

   task automatic send_word(lvsm_pkg::cmd_type c, bit no_idle);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= c.func;
      req_frame_addr <= c.frame_addr;
      req_left_in <= c.left_in;
      req_right_in <= c.right_in;
      req_voice_length <= c.voice_length;
      req_loop_enable <= c.loop_enable;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      lvsm_pkg::cmd_type c;
      lvsm_pkg::rsp_type r;
      bit no_idle;
      for (int i = 0; i < 65536; i++) frame_written[i] = 0;
      for (int v = 0; v < NVOICE; v++) vc_busy[v] = 0;
      add_row(lvsm_pkg::FUNC_TICK, 16'h0000, 16'h0000, 16'h0000, 17'd0, 1'b0, 1, 1'b0);
      add_row(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h10000, 1'b1, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_STORE, 16'h0000, 16'h7FFF, 16'h8000, 17'd0, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_STORE, 16'hFFFF, 16'h8000, 16'h7FFF, 17'd0, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_STORE, 16'h0001, 16'h0001, 16'hFFFF, 17'd0, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_START, 16'h0000, 16'h0000, 16'h0000, 17'd0, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_START, 16'hFFFF, 16'h0000, 16'h0000, 17'd3, 1'b1, 1, 1'b0);
      for (int i = 0; i < 7; i++)
         add_row(lvsm_pkg::FUNC_START, 16'h0000, 16'h0000, 16'h0000, 17'd1, 1'b0, 1, 1'b0);
      // Table is full now, so this start is refused.
      add_row(lvsm_pkg::FUNC_START, 16'h0005, 16'h0000, 16'h0000, 17'd9, 1'b0, 1, 1'b1);
      for (int i = 0; i < 4; i++)
         add_row(lvsm_pkg::FUNC_TICK, 16'h0000, 16'h0000, 16'h0000, 17'd0, 1'b0, 0, 1'b0);
      add_row(lvsm_pkg::FUNC_STORE, 16'hFFFE, 16'h1234, 16'hEDCB, 17'd0, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_START, 16'hFFFE, 16'h0000, 16'h0000, 17'h10000, 1'b0, 1, 1'b0);
      add_row(lvsm_pkg::FUNC_TICK, 16'h0000, 16'h0000, 16'h0000, 17'd0, 1'b0, 0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].cmd, 1'b0);
         r = mix_step(directed_rows[i].cmd);
         pending_mix = {pending_mix, (directed_rows[i].known ? directed_rows[i].res : r)};
      end
      no_idle = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            while (pending_mix.size() != 0) @(posedge clock);
         end
         c = draw_word();
         send_word(c, no_idle);
         pending_mix = {pending_mix, mix_step(c)};
      end
      req_valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb_looping_voice_sample_mixer: clean");
      end else begin
         $display("tb_looping_voice_sample_mixer: errors");
      end
      $finish;
   end

   // Result side: random stalls, with one long hold-off that fills the queue.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 11);
         if (words_out == 300) gap = 250;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      lvsm_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (pending_mix.size() == 0) begin
            $error("unexpected word: left %0d right %0d", rsp_mix_left, rsp_mix_right);
            errors++;
         end else begin
            e = pending_mix.pop_front();
            if (rsp_mix_left !== e.mix_left) begin
               $error("mix_left: expected %0d, got %0d", $signed(e.mix_left), rsp_mix_left);
               errors++;
            end
            if (rsp_mix_right !== e.mix_right) begin
               $error("mix_right: expected %0d, got %0d", $signed(e.mix_right),
                      rsp_mix_right);
               errors++;
            end
            if (rsp_active_voices !== e.active_voices) begin
               $error("active_voices: expected %0d, got %0d", e.active_voices,
                      rsp_active_voices);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_looping_voice_sample_mixer: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
